FILE: rtl/core/rle_nibble_tile_map_decoder_assert.svh
// ============================================================================
// Assertion macros for the nibble-packed tile map decoder
// Clocked implication checks, reset-qualified on an active-low reset.
// ============================================================================
`ifndef RLE_NIBBLE_TILE_MAP_DECODER_ASSERT_SVH
`define RLE_NIBBLE_TILE_MAP_DECODER_ASSERT_SVH

// same-cycle implication
`define RNTM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RNTM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/rntm_pkg.sv
// ============================================================================
// rntm_pkg
// Shared constants for the nibble-packed tile map decoder.
// ============================================================================
package rntm_pkg;

	localparam int unsigned DEF_MAX_ROW_BYTES = 16;
	localparam int unsigned DEF_MAX_ROWS      = 16;

	localparam int unsigned COUNT_W   = 10;
	localparam int unsigned COUNT_MAX = 1023;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 5;

	// operations
	localparam logic [1:0] OP_BEGIN = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// decode modes (code 3 behaves as row order)
	localparam logic [1:0] MODE_RAW = 2'd0;
	localparam logic [1:0] MODE_ROW = 2'd1;
	localparam logic [1:0] MODE_COL = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_ROWS     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DECODE_MODE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COUNTED_TILE = 2'd3;

	// run byte layout
	localparam logic [7:0] TILE_MASK  = 8'hE0;
	localparam logic [7:0] RUN_MASK   = 8'h1F;
	localparam int unsigned TILE_SHIFT = 5;
	localparam logic [7:0] LO_NIBBLE  = 8'h0F;
	localparam logic [7:0] HI_NIBBLE  = 8'hF0;

endpackage

FILE: rtl/core/rntm_div.sv
// ============================================================================
// rntm_div
// Restoring divider, one quotient bit per cycle, shared by all load modes.
// ============================================================================
module rntm_div
	import rntm_pkg::*;
#(
	parameter int unsigned DVD_W = 10,
	parameter int unsigned DVS_W = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient,
	output logic [DVS_W-1:0] remainder
);

	localparam int unsigned CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;

	logic [DVS_W:0] trial;
	logic [DVS_W:0] diff;
	logic           fits;

	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], fits};
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

FILE: rtl/core/rntm_tile_store.sv
// ============================================================================
// rntm_tile_store
// Single-port byte store, read-first, registered read data.
// ============================================================================
module rntm_tile_store
	import rntm_pkg::*;
#(
	parameter int unsigned DEPTH = DEF_MAX_ROW_BYTES * DEF_MAX_ROWS,
	parameter int unsigned AW    = 8
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic          wr_en,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wr_data,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/core/rle_nibble_tile_map_decoder.sv
// ============================================================================
// rle_nibble_tile_map_decoder
// Tile map stream decoder into a nibble-packed 2D store, with tile counting.
// ============================================================================
// Request channel item_valid / item_stall (operation, data_byte, read_col,
// read_row): begin clears cursor, count and flags; load decodes one stream
// byte; read returns one stored byte. Result channel result_valid /
// result_stall (map_byte, tile_count, map_done, overflowed), exactly one
// result per request. Config channel cfg_valid / cfg_ready (always ready),
// cfg_index, cfg_data; write only while no request is in flight.
// Request paths: begin, unknown op, terminator and out-of-range read go
// straight to the finish step; an in-range read reads the store, then
// finishes; a raw load divides, checks and writes; a run-length load
// divides, then checks, reads and writes per tile; a byte or tile past the
// grid end stops at the check. The shared bit-serial divider splits the
// cursor (10 bits wide by default) once per load except a terminator; each
// run tile costs check, read and write on the single store port, a raw byte check and write.
// One request at a time: item_stall is high from accept until the result
// enters the output register; a finished request waits while result_stall
// holds a previous result. Reset restores cursor, count, flags and config
// defaults; the store is not cleared and is undefined until written.
// ============================================================================
`include "rle_nibble_tile_map_decoder_assert.svh"

module rle_nibble_tile_map_decoder
	import rntm_pkg::*;
#(
	parameter int unsigned MAX_ROW_BYTES = DEF_MAX_ROW_BYTES,
	parameter int unsigned MAX_ROWS      = DEF_MAX_ROWS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// config
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// requests
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic [1:0]            operation,
	input  logic [7:0]            data_byte,
	input  logic [3:0]            read_col,
	input  logic [3:0]            read_row,
	// results
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [7:0]            map_byte,
	output logic [COUNT_W-1:0]    tile_count,
	output logic                  map_done,
	output logic                  overflowed
);

	localparam int unsigned DEPTH   = MAX_ROW_BYTES * MAX_ROWS;
	localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW      = $clog2(2 * DEPTH + 1);
	localparam int unsigned RBW     = $clog2(MAX_ROW_BYTES + 1);
	localparam int unsigned HW      = $clog2(MAX_ROWS + 1);
	localparam int unsigned DVS_MAX = (2 * MAX_ROW_BYTES > MAX_ROWS) ?
		2 * MAX_ROW_BYTES : MAX_ROWS;
	localparam int unsigned DW      = $clog2(DVS_MAX + 1);

	// sequencer states
	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DIV     = 4'd1;
	localparam logic [3:0] S_CHECK   = 4'd2;
	localparam logic [3:0] S_RAW_WR  = 4'd3;
	localparam logic [3:0] S_RMW_RD  = 4'd4;
	localparam logic [3:0] S_RMW_WR  = 4'd5;
	localparam logic [3:0] S_RD_REQ  = 4'd6;
	localparam logic [3:0] S_RD_WAIT = 4'd7;
	localparam logic [3:0] S_FINISH  = 4'd8;

	// config registers
	logic [CFG_DATA_W-1:0] row_bytes_q;
	logic [CFG_DATA_W-1:0] map_rows_q;
	logic [1:0]            decode_mode_q;
	logic [3:0]            counted_tile_q;

	// map state
	logic [CW-1:0]      cursor_q;
	logic [COUNT_W-1:0] count_q;
	logic               done_q;
	logic               ovf_q;
	logic [CW-1:0]      grid_q;

	// per-request working registers
	logic [3:0]    state_q;
	logic          is_load_q;
	logic [7:0]    data_q;
	logic [2:0]    tile_q;
	logic [4:0]    run_left_q;
	logic [DW-1:0] divisor_q;
	logic [CW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [AW-1:0] mem_addr_q;
	logic          high_q;
	logic [7:0]    byte_q;

	// result register
	logic               result_valid_q;
	logic [7:0]         map_byte_q;
	logic [COUNT_W-1:0] tile_count_q;
	logic               map_done_q;
	logic               overflowed_q;

	// geometry
	logic [RBW-1:0]     w_eff;
	logic [HW-1:0]      h_eff;
	logic [RBW+HW-1:0]  area;
	logic [COUNT_W-1:0] cap;
	logic               mode_raw;
	logic               mode_col;

	// divider hookup
	logic          div_start;
	logic [CW-1:0] div_dividend;
	logic [DW-1:0] div_divisor;
	logic          div_done;
	logic [CW-1:0] div_quo;
	logic [DW-1:0] div_rem;

	// addressing and store port
	logic          accept;
	logic          rd_in_range;
	logic [AW-1:0] rd_addr;
	logic [CW-1:0] a_row;
	logic [CW-1:0] a_col;
	logic [AW-1:0] tile_addr;
	logic          tile_high;
	logic [CW-1:0] limit;
	logic          mem_rd_en;
	logic          mem_wr_en;
	logic [7:0]    mem_wdata;
	logic [7:0]    mem_rdata;
	logic [7:0]    merged;
	logic [3:0]    tile4;

	// counting
	logic [1:0]         hits;
	logic [COUNT_W:0]   count_sum;
	logic [COUNT_W-1:0] count_next;
	logic               fin_done;
	logic               out_free;

	// --- geometry: zero acts as one, large values clamp to the store size
	always_comb begin
		if (row_bytes_q == '0) begin
			w_eff = RBW'(1);
		end else if (int'(row_bytes_q) > int'(MAX_ROW_BYTES)) begin
			w_eff = RBW'(MAX_ROW_BYTES);
		end else begin
			w_eff = RBW'(row_bytes_q);
		end
		if (map_rows_q == '0) begin
			h_eff = HW'(1);
		end else if (int'(map_rows_q) > int'(MAX_ROWS)) begin
			h_eff = HW'(MAX_ROWS);
		end else begin
			h_eff = HW'(map_rows_q);
		end
	end

	assign area     = (RBW+HW)'(w_eff) * (RBW+HW)'(h_eff);
	assign mode_raw = (decode_mode_q == MODE_RAW);
	assign mode_col = (decode_mode_q == MODE_COL);

	// count saturates at grid size and at the counter limit
	always_comb begin
		if (int'(grid_q) > int'(COUNT_MAX)) begin
			cap = COUNT_W'(COUNT_MAX);
		end else begin
			cap = COUNT_W'(grid_q);
		end
	end

	// --- request side
	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;

	assign rd_in_range = (int'(read_col) < int'(w_eff)) && (int'(read_row) < int'(h_eff));
	assign rd_addr     = AW'(int'(read_row) * int'(MAX_ROW_BYTES) + int'(read_col));

	// raw mode divides the byte position by the width; run modes divide the
	// tile cursor by the tiles per row (row order) or the rows (column order)
	always_comb begin
		if (mode_raw) begin
			div_dividend = {1'b0, cursor_q[CW-1:1]};
			div_divisor  = DW'(w_eff);
		end else if (mode_col) begin
			div_dividend = cursor_q;
			div_divisor  = DW'(h_eff);
		end else begin
			div_dividend = cursor_q;
			div_divisor  = DW'({w_eff, 1'b0});
		end
	end

	assign div_start = accept && (operation == OP_LOAD) &&
		(mode_raw || ((data_byte & RUN_MASK) != 8'h00));

	rntm_div #(
		.DVD_W (CW),
		.DVS_W (DW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// --- tile position to store address
	always_comb begin
		if (mode_raw) begin
			a_row     = quo_q;
			a_col     = CW'(rem_q);
			tile_high = 1'b0;
			limit     = CW'(h_eff);
		end else if (mode_col) begin
			a_row     = CW'(rem_q);
			a_col     = quo_q >> 1;
			tile_high = ~quo_q[0];
			limit     = CW'({w_eff, 1'b0});
		end else begin
			a_row     = quo_q;
			a_col     = CW'(rem_q >> 1);
			tile_high = ~rem_q[0];
			limit     = CW'(h_eff);
		end
	end

	assign tile_addr = AW'(int'(a_row) * int'(MAX_ROW_BYTES) + int'(a_col));

	// --- store port
	assign tile4     = {1'b0, tile_q};
	assign merged    = high_q ? {tile4, mem_rdata[3:0]} : {mem_rdata[7:4], tile4};
	assign mem_rd_en = (state_q == S_RD_REQ) || (state_q == S_RMW_RD);
	assign mem_wr_en = (state_q == S_RAW_WR) || (state_q == S_RMW_WR);
	assign mem_wdata = (state_q == S_RAW_WR) ? data_q : merged;

	rntm_tile_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.rd_en   (mem_rd_en),
		.wr_en   (mem_wr_en),
		.addr    (mem_addr_q),
		.wr_data (mem_wdata),
		.rd_data (mem_rdata)
	);

	// --- counting: raw bytes carry two tiles, runs one
	always_comb begin
		if (state_q == S_RAW_WR) begin
			hits = 2'((data_q[7:4] == counted_tile_q)) + 2'((data_q[3:0] == counted_tile_q));
		end else begin
			hits = 2'((tile4 == counted_tile_q));
		end
		count_sum = {1'b0, count_q} + (COUNT_W+1)'(hits);
		if (count_q >= cap) begin
			count_next = count_q;
		end else if (count_sum > {1'b0, cap}) begin
			count_next = cap;
		end else begin
			count_next = count_sum[COUNT_W-1:0];
		end
	end

	assign fin_done = done_q || (is_load_q && (cursor_q >= grid_q));
	assign out_free = !result_valid_q || !result_stall;

	// --- config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q    <= CFG_DATA_W'(14);
			map_rows_q     <= CFG_DATA_W'(16);
			decode_mode_q  <= MODE_ROW;
			counted_tile_q <= 4'd0;
			grid_q         <= '0;
		end else begin
			grid_q <= CW'({area, 1'b0});
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_ROW_BYTES: begin
						row_bytes_q <= cfg_data;
					end
					REG_MAP_ROWS: begin
						map_rows_q <= cfg_data;
					end
					REG_DECODE_MODE: begin
						decode_mode_q <= cfg_data[1:0];
					end
					REG_COUNTED_TILE: begin
						counted_tile_q <= cfg_data[3:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// --- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cursor_q       <= '0;
			count_q        <= '0;
			done_q         <= 1'b0;
			ovf_q          <= 1'b0;
			is_load_q      <= 1'b0;
			data_q         <= '0;
			tile_q         <= '0;
			run_left_q     <= '0;
			divisor_q      <= '0;
			quo_q          <= '0;
			rem_q          <= '0;
			mem_addr_q     <= '0;
			high_q         <= 1'b0;
			byte_q         <= '0;
			result_valid_q <= 1'b0;
			map_byte_q     <= '0;
			tile_count_q   <= '0;
			map_done_q     <= 1'b0;
			overflowed_q   <= 1'b0;
		end else begin
			// new result replaces a taken one in the same cycle
			if ((state_q == S_FINISH) && out_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						byte_q    <= 8'h00;
						is_load_q <= 1'b0;
						state_q   <= S_FINISH;
						unique case (operation)
							OP_BEGIN: begin
								cursor_q <= '0;
								count_q  <= '0;
								done_q   <= 1'b0;
								ovf_q    <= 1'b0;
							end
							OP_LOAD: begin
								is_load_q  <= 1'b1;
								data_q     <= data_byte;
								tile_q     <= 3'((data_byte & TILE_MASK) >> TILE_SHIFT);
								run_left_q <= 5'(data_byte & RUN_MASK);
								divisor_q  <= div_divisor;
								if (div_start) begin
									state_q <= S_DIV;
								end else begin
									// terminator
									done_q <= 1'b1;
								end
							end
							OP_READ: begin
								if (rd_in_range) begin
									mem_addr_q <= rd_addr;
									state_q    <= S_RD_REQ;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_DIV: begin
					if (div_done) begin
						quo_q   <= div_quo;
						rem_q   <= div_rem;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					// past the grid end: every remaining tile is dropped
					if (quo_q >= limit) begin
						ovf_q   <= 1'b1;
						state_q <= S_FINISH;
					end else begin
						mem_addr_q <= tile_addr;
						high_q     <= tile_high;
						state_q    <= mode_raw ? S_RAW_WR : S_RMW_RD;
					end
				end
				S_RAW_WR: begin
					count_q  <= count_next;
					cursor_q <= {cursor_q[CW-1:1], 1'b0} + CW'(2);
					state_q  <= S_FINISH;
				end
				S_RMW_RD: begin
					state_q <= S_RMW_WR;
				end
				S_RMW_WR: begin
					count_q    <= count_next;
					cursor_q   <= cursor_q + CW'(1);
					run_left_q <= run_left_q - 5'd1;
					if (rem_q == divisor_q - DW'(1)) begin
						rem_q <= '0;
						quo_q <= quo_q + CW'(1);
					end else begin
						rem_q <= rem_q + DW'(1);
					end
					state_q <= (run_left_q == 5'd1) ? S_FINISH : S_CHECK;
				end
				S_RD_REQ: begin
					state_q <= S_RD_WAIT;
				end
				S_RD_WAIT: begin
					byte_q  <= mem_rdata;
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (out_free) begin
						done_q       <= fin_done;
						map_byte_q   <= byte_q;
						tile_count_q <= count_q;
						map_done_q   <= fin_done;
						overflowed_q <= ovf_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign map_byte     = map_byte_q;
	assign tile_count   = tile_count_q;
	assign map_done     = map_done_q;
	assign overflowed   = overflowed_q;

	// --- checks
	`RNTM_ASSERT_NXT(a_div_start_seq, clk, arst_n, div_start, state_q == S_DIV,
		"divider started without sequencer waiting on it")
	`RNTM_ASSERT_IMP(a_div_done_seq, clk, arst_n, div_done, state_q == S_DIV,
		"divider finished outside the divide wait")
	`RNTM_ASSERT_IMP(a_write_in_grid, clk, arst_n, state_q == S_RMW_WR, cursor_q < grid_q,
		"tile write with cursor past the grid end")
	`RNTM_ASSERT_IMP(a_result_from_finish, clk, arst_n, $rose(result_valid_q),
		$past(state_q) == S_FINISH, "result presented outside the finish step")

endmodule
